// ===== hdl/ami_pkg.sv =====
package ami_pkg;

    // Row code of the translation row
    localparam logic [1:0] ROW_TRANS = 2'd3;

    localparam logic [15:0] EPS_RESET = 16'd26;

    localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    // Cofactor product operands, element index r*3+c: adj = m[PA0]*m[PA1] - m[PB0]*m[PB1]
    localparam int unsigned ADJ_PA [0:8][0:1] = '{
        '{4, 8}, '{2, 7}, '{1, 5},
        '{5, 6}, '{0, 8}, '{2, 3},
        '{3, 7}, '{1, 6}, '{0, 4}
    };
    localparam int unsigned ADJ_PB [0:8][0:1] = '{
        '{5, 7}, '{1, 8}, '{2, 4},
        '{3, 8}, '{2, 6}, '{0, 5},
        '{4, 6}, '{0, 7}, '{1, 3}
    };

    typedef struct packed {
        logic [1:0]         row;
        logic               singular;
        logic               last;
        logic [2:0]         neg;
        logic signed [31:0] tk;
    } sb_t;

endpackage

// ===== hdl/affine_matrix_inverse.sv =====
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_stall    r0c0..r2c2, tx, ty, tz
// out       output     out_valid/out_stall  row_index, col0..col2, singular, last
// cfg       input      det_epsilon_we       det_epsilon
//
// A regular matrix gives four words, one per row slot, and a singular one gives one;
// the row sequencer after the determinant stage holds the input until the last slot of
// a matrix is issued. A word passes 43 register stages from input to output register
// (6 front, 34 divider (a head and 33 quotient-bit stages, three lanes), 2 post,
// output); the translation row follows the three other rows of its matrix.
// Reset clears all valid bits and loads det_epsilon with 26.
// out_stall freezes the whole pipeline; nothing is dropped or repeated.
module affine_matrix_inverse #(
    parameter int FRACTION_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               det_epsilon_we,
    input  logic [15:0]        det_epsilon,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] r0c0,
    input  logic signed [31:0] r0c1,
    input  logic signed [31:0] r0c2,
    input  logic signed [31:0] r1c0,
    input  logic signed [31:0] r1c1,
    input  logic signed [31:0] r1c2,
    input  logic signed [31:0] r2c0,
    input  logic signed [31:0] r2c1,
    input  logic signed [31:0] r2c2,
    input  logic signed [31:0] tx,
    input  logic signed [31:0] ty,
    input  logic signed [31:0] tz,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         row_index,
    output logic signed [31:0] col0,
    output logic signed [31:0] col1,
    output logic signed [31:0] col2,
    output logic               singular,
    output logic               last
);

    localparam int DW = 98;
    localparam int MW = 97;
    localparam int XW = (2 * FRACTION_BITS + 67 > 131) ? 2 * FRACTION_BITS + 67 : 131;
    localparam int AW = 67;
    localparam int DS = 33;

    logic en;
    logic front_en;
    logic slot_last;

    logic [15:0] eps_reg;

    logic               f0_valid_reg;
    logic signed [31:0] f0_m_reg [0:8];
    logic signed [31:0] f0_t_reg [0:2];

    logic               f1_valid_reg;
    logic signed [63:0] f1_pa_reg [0:8];
    logic signed [63:0] f1_pb_reg [0:8];
    logic signed [31:0] f1_m0_reg [0:2];
    logic signed [31:0] f1_t_reg [0:2];

    logic               f2_valid_reg;
    logic signed [63:0] f2_adj_reg [0:8];
    logic signed [31:0] f2_m0_reg [0:2];
    logic signed [31:0] f2_t_reg [0:2];

    logic               f3_valid_reg;
    logic signed [64:0] f3_lo_reg [0:2];
    logic signed [63:0] f3_hi_reg [0:2];
    logic signed [63:0] f3_adj_reg [0:8];
    logic signed [31:0] f3_t_reg [0:2];

    logic               f4_valid_reg;
    logic signed [DW-1:0] f4_det_reg;
    logic signed [DW-1:0] det_next;
    logic signed [63:0] f4_adj_reg [0:8];
    logic signed [31:0] f4_t_reg [0:2];

    logic               f5_valid_reg;
    logic [MW-1:0]      f5_dmag_reg;
    logic               f5_dneg_reg;
    logic               f5_sing_reg;
    logic signed [63:0] f5_adj_reg [0:8];
    logic signed [31:0] f5_t_reg [0:2];
    logic [1:0]         slot_cnt_reg;

    logic signed [DW-1:0] det_abs;
    logic [MW-1:0]      dmag_next;
    logic [MW-1:0]      thr;

    logic signed [63:0] sel_adj [0:2];
    logic signed [31:0] sel_t;
    logic [63:0]        sel_mag [0:2];
    ami_pkg::sb_t       slot_sb;

    logic               dv_valid_reg [0:DS];
    logic [XW-1:0]      dv_rem_reg [0:DS][0:2];
    logic [DS-1:0]      dv_q_reg [0:DS][0:2];
    logic [MW:0]        dv_d_reg [0:DS];
    ami_pkg::sb_t       dv_sb_reg [0:DS];

    logic               p1_valid_reg;
    logic signed [31:0] p1_inv_reg [0:2];
    ami_pkg::sb_t       p1_sb_reg;
    logic signed [31:0] inv_next [0:2];

    logic               p2_valid_reg;
    logic signed [31:0] p2_inv_reg [0:2];
    logic signed [63:0] p2_prod_reg [0:2];
    ami_pkg::sb_t       p2_sb_reg;

    logic signed [AW-1:0] acc_reg [0:2];
    logic signed [AW-1:0] tr_sum [0:2];
    logic signed [AW-1:0] tr_shift [0:2];
    logic signed [31:0] tr_val [0:2];
    logic signed [31:0] col_next [0:2];

    logic               out_valid_reg;
    logic [1:0]         row_index_reg;
    logic signed [31:0] col_reg [0:2];
    logic               singular_reg;
    logic               last_reg;

    // Whole pipeline advances when the output register is free or taken
    assign en        = !out_valid_reg || !out_stall;
    assign slot_last = f5_sing_reg || (slot_cnt_reg == ami_pkg::ROW_TRANS);
    assign front_en  = en && (!f5_valid_reg || slot_last);
    assign in_stall  = !front_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= ami_pkg::EPS_RESET;
        end
        else if (det_epsilon_we)
        begin
            eps_reg <= det_epsilon;
        end
    end

    // Front: cofactor products, adjugate, determinant partials, determinant, magnitude
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            f4_valid_reg <= 1'b0;
            f5_valid_reg <= 1'b0;
        end
        else if (front_en)
        begin
            f0_valid_reg <= in_valid;
            f1_valid_reg <= f0_valid_reg;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
            f4_valid_reg <= f3_valid_reg;
            f5_valid_reg <= f4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_en)
        begin
            f0_m_reg[0] <= r0c0;
            f0_m_reg[1] <= r0c1;
            f0_m_reg[2] <= r0c2;
            f0_m_reg[3] <= r1c0;
            f0_m_reg[4] <= r1c1;
            f0_m_reg[5] <= r1c2;
            f0_m_reg[6] <= r2c0;
            f0_m_reg[7] <= r2c1;
            f0_m_reg[8] <= r2c2;
            f0_t_reg[0] <= tx;
            f0_t_reg[1] <= ty;
            f0_t_reg[2] <= tz;
            for (int i = 0; i < 9; i++)
            begin
                f1_pa_reg[i] <= f0_m_reg[ami_pkg::ADJ_PA[i][0]] * f0_m_reg[ami_pkg::ADJ_PA[i][1]];
                f1_pb_reg[i] <= f0_m_reg[ami_pkg::ADJ_PB[i][0]] * f0_m_reg[ami_pkg::ADJ_PB[i][1]];
                f2_adj_reg[i] <= f1_pa_reg[i] - f1_pb_reg[i];
                f3_adj_reg[i] <= f2_adj_reg[i];
                f4_adj_reg[i] <= f3_adj_reg[i];
                f5_adj_reg[i] <= f4_adj_reg[i];
            end
            for (int j = 0; j < 3; j++)
            begin
                f1_m0_reg[j] <= f0_m_reg[j];
                f2_m0_reg[j] <= f1_m0_reg[j];
                f3_lo_reg[j] <= f2_m0_reg[j] * $signed({1'b0, f2_adj_reg[3*j][31:0]});
                f3_hi_reg[j] <= f2_m0_reg[j] * $signed(f2_adj_reg[3*j][63:32]);
                f1_t_reg[j] <= f0_t_reg[j];
                f2_t_reg[j] <= f1_t_reg[j];
                f3_t_reg[j] <= f2_t_reg[j];
                f4_t_reg[j] <= f3_t_reg[j];
                f5_t_reg[j] <= f4_t_reg[j];
            end
            f4_det_reg  <= det_next;
            f5_dmag_reg <= dmag_next;
            f5_dneg_reg <= f4_det_reg[DW-1];
            f5_sing_reg <= (dmag_next == '0) || (dmag_next < thr);
        end
    end

    always_comb
    begin
        det_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            det_next = det_next + (DW'(f3_hi_reg[j]) <<< 32) + DW'(f3_lo_reg[j]);
        end
    end

    assign det_abs   = f4_det_reg[DW-1] ? -f4_det_reg : f4_det_reg;
    assign dmag_next = det_abs[MW-1:0];
    assign thr       = MW'(eps_reg) << (2 * FRACTION_BITS);

    // Row sequencer: one slot per row, translation row last; a singular matrix takes a single slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_cnt_reg <= '0;
        end
        else if (en && f5_valid_reg)
        begin
            slot_cnt_reg <= slot_last ? 2'd0 : slot_cnt_reg + 2'd1;
        end
    end

    always_comb
    begin
        unique case (slot_cnt_reg)
            2'd0:
            begin
                sel_adj = '{f5_adj_reg[0], f5_adj_reg[1], f5_adj_reg[2]};
                sel_t   = f5_t_reg[0];
            end
            2'd1:
            begin
                sel_adj = '{f5_adj_reg[3], f5_adj_reg[4], f5_adj_reg[5]};
                sel_t   = f5_t_reg[1];
            end
            2'd2:
            begin
                sel_adj = '{f5_adj_reg[6], f5_adj_reg[7], f5_adj_reg[8]};
                sel_t   = f5_t_reg[2];
            end
            ami_pkg::ROW_TRANS:
            begin
                sel_adj = '{64'sd0, 64'sd0, 64'sd0};
                sel_t   = '0;
            end
        endcase
        for (int l = 0; l < 3; l++)
        begin
            sel_mag[l]     = sel_adj[l][63] ? 64'(-sel_adj[l]) : 64'(sel_adj[l]);
            slot_sb.neg[l] = sel_adj[l][63] ^ f5_dneg_reg;
        end
        slot_sb.row      = slot_cnt_reg;
        slot_sb.singular = f5_sing_reg;
        slot_sb.last     = slot_last;
        slot_sb.tk       = sel_t;
    end

    // Divider head: rem = 2*|adj|*2^(2F) + |det|, divisor 2*|det|
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_valid_reg[0] <= f5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                dv_rem_reg[0][l] <= (XW'(sel_mag[l]) << (2 * FRACTION_BITS + 1))
                                    + XW'(f5_dmag_reg);
                dv_q_reg[0][l]   <= '0;
            end
            dv_d_reg[0]  <= {f5_dmag_reg, 1'b0};
            dv_sb_reg[0] <= slot_sb;
        end
    end

    // One quotient bit per stage, bit 32 first; a set bit 32 means overflow
    for (genvar s = 1; s <= DS; s++)
    begin : g_div
        logic [XW-1:0] dsh;
        logic [2:0]    qbit;

        assign dsh = XW'(dv_d_reg[s-1]) << (DS - s);

        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            assign qbit[l] = dv_rem_reg[s-1][l] >= dsh;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_rem_reg[s][l] <= qbit[l] ? dv_rem_reg[s-1][l] - dsh : dv_rem_reg[s-1][l];
                    dv_q_reg[s][l]   <= {dv_q_reg[s-1][l][DS-2:0], qbit[l]};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[s] <= dv_valid_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_d_reg[s]  <= dv_d_reg[s-1];
                dv_sb_reg[s] <= dv_sb_reg[s-1];
            end
        end
    end

    // Sign and saturate the quotients
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (!dv_sb_reg[DS].neg[l])
            begin
                inv_next[l] = (dv_q_reg[DS][l][32] || dv_q_reg[DS][l][31])
                              ? ami_pkg::SAT_MAX : $signed(dv_q_reg[DS][l][31:0]);
            end
            else
            begin
                inv_next[l] = (dv_q_reg[DS][l][32]
                               || (dv_q_reg[DS][l][31] && (|dv_q_reg[DS][l][30:0])))
                              ? ami_pkg::SAT_MIN : -$signed(dv_q_reg[DS][l][31:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= dv_valid_reg[DS];
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                p1_inv_reg[l]  <= inv_next[l];
                p2_inv_reg[l]  <= p1_inv_reg[l];
                p2_prod_reg[l] <= p1_sb_reg.tk * p1_inv_reg[l];
            end
            p1_sb_reg <= dv_sb_reg[DS];
            p2_sb_reg <= p1_sb_reg;
        end
    end

    // Translation: accumulate t[k]*inv[k][j] over rows, then negate, round, saturate
    always_ff @(posedge clk)
    begin
        if (en && p2_valid_reg && !p2_sb_reg.singular && p2_sb_reg.row != ami_pkg::ROW_TRANS)
        begin
            for (int l = 0; l < 3; l++)
            begin
                acc_reg[l] <= ((p2_sb_reg.row == 2'd0) ? AW'(0) : acc_reg[l])
                              + AW'(p2_prod_reg[l]);
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            tr_sum[l]   = -acc_reg[l] + (AW'(1) <<< (FRACTION_BITS - 1));
            tr_shift[l] = tr_sum[l] >>> FRACTION_BITS;
            if ((&tr_shift[l][AW-1:31]) || !(|tr_shift[l][AW-1:31]))
            begin
                tr_val[l] = tr_shift[l][31:0];
            end
            else
            begin
                tr_val[l] = tr_shift[l][AW-1] ? ami_pkg::SAT_MIN : ami_pkg::SAT_MAX;
            end
        end
        for (int l = 0; l < 3; l++)
        begin
            priority if (p2_sb_reg.singular)
            begin
                col_next[l] = '0;
            end
            else if (p2_sb_reg.row == ami_pkg::ROW_TRANS)
            begin
                col_next[l] = tr_val[l];
            end
            else
            begin
                col_next[l] = p2_inv_reg[l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_index_reg <= p2_sb_reg.row;
            singular_reg  <= p2_sb_reg.singular;
            last_reg      <= p2_sb_reg.last;
            for (int l = 0; l < 3; l++)
            begin
                col_reg[l] <= col_next[l];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign row_index = row_index_reg;
    assign col0      = col_reg[0];
    assign col1      = col_reg[1];
    assign col2      = col_reg[2];
    assign singular  = singular_reg;
    assign last      = last_reg;

    a_seq_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        f5_valid_reg && !slot_last |-> in_stall)
        else $error("input taken while rows still pending");

    a_sing_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
        f5_valid_reg && f5_sing_reg |-> slot_cnt_reg == 2'd0)
        else $error("singular matrix issued more than one row");

    a_sing_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> last && row_index == 2'd0 && col0 == 32'sd0)
        else $error("malformed singular word");

    a_last_trans: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !singular |-> last == (row_index == ami_pkg::ROW_TRANS))
        else $error("last flag not on translation row");

    a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
        en && f5_valid_reg && !slot_last |=> slot_cnt_reg == $past(slot_cnt_reg) + 2'd1)
        else $error("row sequencer skipped a row");

endmodule
